[rtl/d2d_pkg.sv]
// Shared types and constants for the disparity-to-depth colouriser.
// No dependencies; imported by the top level disparity_to_depth_colorizer.
package d2d_pkg;

    localparam int ZW = 36;   // depth quotient width (24-bit scale << 12)
    localparam int DSW = 15;  // magnitude of a positive disparity
    localparam int FW = 16;   // focal length width
    localparam int MW = 10;   // magnitude of a centred row / column offset
    localparam int PW = ZW + MW;  // reprojection product width

    localparam logic [23:0] COLOR_GRAY = 24'h646464;
    localparam logic [23:0] COLOR_FAR = 24'hA8008C;
    localparam logic [23:0] COLOR_NEAR = 24'h000000;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_UNM   = 3'd1,
        KIND_RANGE = 3'd2,
        KIND_FAR   = 3'd3,
        KIND_NEAR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_DEPTH_SCALE  = 3'd0,
        CFG_FOCAL        = 3'd1,
        CFG_MOUNT_HEIGHT = 3'd2,
        CFG_NEAR         = 3'd3,
        CFG_FAR          = 3'd4,
        CFG_COLOR_EN     = 3'd5,
        CFG_DISP_COUNT   = 3'd6
    } t_cfg_idx;

    // Request data carried alongside the divider cells
    typedef struct packed {
        logic          cmd;
        logic [9:0]    row;
        logic [9:0]    col;
        logic [11:0]   pal_idx;
        logic [23:0]   pal_color;
        logic          skip;
        logic          unm;
        logic          sx;
        logic          sy;
        logic [ZW-1:0] z;
    } t_item;

endpackage

[rtl/d2d_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module d2d_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/d2d_div_cell.sv]
// One restoring-division cell: one quotient bit per lane, shared divisor.
// No package dependency.
module d2d_div_cell #(
    parameter int NW = 36,
    parameter int DW = 15,
    parameter int LANES = 1,
    parameter int SW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [DW-1:0]               i_den,
    input  logic [LANES-1:0][DW-1:0]    i_rem,
    input  logic [LANES-1:0][NW-1:0]    i_nq,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [DW-1:0]               o_den,
    output logic [LANES-1:0][DW-1:0]    o_rem,
    output logic [LANES-1:0][NW-1:0]    o_nq,
    output logic [SW-1:0]               o_side
);
    logic                     r_valid;
    logic [DW-1:0]            r_den;
    logic [LANES-1:0][DW-1:0] r_rem, n_rem;
    logic [LANES-1:0][NW-1:0] r_nq, n_nq;
    logic [SW-1:0]            r_side;
    logic [LANES-1:0][DW:0]   w_trial, w_diff;
    logic [LANES-1:0]         w_ge;

    // nq holds remaining dividend bits above, quotient bits shifting in below
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_trial[l] = {i_rem[l], i_nq[l][NW-1]};
            w_diff[l]  = w_trial[l] - {1'b0, i_den};
            w_ge[l]    = (w_trial[l] >= {1'b0, i_den});
            n_rem[l]   = w_ge[l] ? w_diff[l][DW-1:0] : w_trial[l][DW-1:0];
            n_nq[l]    = {i_nq[l][NW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_side  = r_side;
endmodule

[rtl/d2d_div_chain.sv]
// Row of NW restoring-division cells; the quotient leaves the last cell.
// Depends on d2d_div_cell.
module d2d_div_chain #(
    parameter int NW = 36,
    parameter int DW = 15,
    parameter int LANES = 1,
    parameter int SW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [DW-1:0]            i_den,
    input  logic [LANES-1:0][NW-1:0] i_num,
    input  logic [SW-1:0]            i_side,
    output logic                     o_valid,
    output logic [LANES-1:0][NW-1:0] o_quo,
    output logic [SW-1:0]            o_side
);
    logic                     w_valid [NW+1];
    logic [DW-1:0]            w_den   [NW+1];
    logic [LANES-1:0][DW-1:0] w_rem   [NW+1];
    logic [LANES-1:0][NW-1:0] w_nq    [NW+1];
    logic [SW-1:0]            w_side  [NW+1];

    assign w_valid[0] = i_valid;
    assign w_den[0]   = i_den;
    assign w_rem[0]   = '0;
    assign w_nq[0]    = i_num;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        d2d_div_cell #(.NW(NW), .DW(DW), .LANES(LANES), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_den   (w_den[k]),
            .i_rem   (w_rem[k]),
            .i_nq    (w_nq[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_den   (w_den[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_nq    (w_nq[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    assign o_valid = w_valid[NW];
    assign o_quo   = w_nq[NW];
    assign o_side  = w_side[NW];
endmodule

[rtl/disparity_to_depth_colorizer.sv]
// Top level: disparity to depth / X / Y reprojection with palette colouring.
// Depends on d2d_pkg, d2d_div_chain, d2d_ram.
//
//  channel | signals                          | direction | handshake
//  --------+----------------------------------+-----------+----------------------
//  in      | i_command .. i_palette_color     | to block  | i_in_valid / o_in_stall
//  out     | o_pixel_kind .. o_color_written  | from block| o_out_valid / i_out_stall
//  cfg     | i_cfg_index, i_cfg_data          | to block  | i_cfg_valid / o_cfg_ready
//
// One request per clock while the output is not stalled. A pixel result passes through
// 36 depth divider cells, a multiply register, 46 X/Y divider cells (one
// quotient bit per cell), a palette lookup register and the output register.
// Palette writes flow down the same pipe and update the RAM in order.
// Reset restores the configuration defaults and clears every valid bit; the palette is not cleared.
// A stalled output register freezes the whole pipe, and the input stalls with it.
module disparity_to_depth_colorizer #(
    parameter int IMAGE_WIDTH = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int PALETTE_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [9:0]           i_pixel_row,
    input  logic [9:0]           i_pixel_col,
    input  logic signed [15:0]   i_raw_disparity,
    input  logic [11:0]          i_palette_index,
    input  logic [23:0]          i_palette_color,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_pixel_kind,
    output logic signed [36:0]   o_depth_z,
    output logic signed [47:0]   o_pos_x,
    output logic signed [47:0]   o_pos_y,
    output logic [23:0]          o_pixel_color,
    output logic                 o_color_written,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    import d2d_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int SW = $bits(t_item);

    // ---------------- configuration registers ----------------
    logic [23:0] r_depth_scale;
    logic [15:0] r_focal;
    logic [23:0] r_mount;
    logic [15:0] r_near;
    logic [15:0] r_far;
    logic        r_col_en;
    logic [8:0]  r_disp_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= 24'd1000;
            r_focal       <= 16'd700;
            r_mount       <= 24'd0;
            r_near        <= 16'd0;
            r_far         <= 16'd4095;
            r_col_en      <= 1'b0;
            r_disp_cnt    <= 9'd128;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEPTH_SCALE:  r_depth_scale <= i_cfg_data;
                CFG_FOCAL:        r_focal       <= i_cfg_data[15:0];
                CFG_MOUNT_HEIGHT: r_mount       <= i_cfg_data;
                CFG_NEAR:         r_near        <= i_cfg_data[15:0];
                CFG_FAR:          r_far         <= i_cfg_data[15:0];
                CFG_COLOR_EN:     r_col_en      <= i_cfg_data[0];
                CFG_DISP_COUNT:   r_disp_cnt    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    // whole pipe moves together unless the output register is held
    logic w_adv;
    logic r_out_valid;
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // ---------------- entry: classify, start depth division ----------------
    t_item w_in_item;
    always_comb begin
        w_in_item           = '0;
        w_in_item.cmd       = i_command;
        w_in_item.row       = i_pixel_row;
        w_in_item.col       = i_pixel_col;
        w_in_item.pal_idx   = i_palette_index;
        w_in_item.pal_color = i_palette_color;
        w_in_item.skip      = (i_pixel_col < {2'b00, r_disp_cnt[8:1]});
        w_in_item.unm       = (i_raw_disparity <= 16'sd0);
    end

    logic [0:0][ZW-1:0] w_z_num, w_z_quo;
    logic               w_c1_valid;
    logic [SW-1:0]      w_c1_side;
    assign w_z_num[0] = {r_depth_scale, 12'b0};

    // Z = (depth_scale << 12) / raw, one bit per cell
    d2d_div_chain #(.NW(ZW), .DW(DSW), .LANES(1), .SW(SW)) u_zdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in_valid),
        .i_den   (i_raw_disparity[DSW-1:0]),
        .i_num   (w_z_num),
        .i_side  (SW'(w_in_item)),
        .o_valid (w_c1_valid),
        .o_quo   (w_z_quo),
        .o_side  (w_c1_side)
    );

    // ---------------- multiply stage ----------------
    t_item             w_c1_item;
    t_item             n_m_item;
    logic signed [11:0] w_dx, w_dy;
    logic [11:0]       w_adx, w_ady;
    logic [PW-1:0]     w_px, w_py;

    assign w_c1_item = t_item'(w_c1_side);
    assign w_dx  = $signed({2'b00, w_c1_item.col}) - $signed(12'(IMAGE_WIDTH / 2));
    assign w_dy  = $signed(12'(IMAGE_HEIGHT / 2)) - $signed({2'b00, w_c1_item.row});
    assign w_adx = w_dx[11] ? 12'(-w_dx) : 12'(w_dx);
    assign w_ady = w_dy[11] ? 12'(-w_dy) : 12'(w_dy);
    assign w_px  = PW'(w_adx[MW-1:0]) * PW'(w_z_quo[0]);
    assign w_py  = PW'(w_ady[MW-1:0]) * PW'(w_z_quo[0]);

    // depth and offset signs ride along with the request
    always_comb begin
        n_m_item    = w_c1_item;
        n_m_item.z  = w_z_quo[0];
        n_m_item.sx = w_dx[11];
        n_m_item.sy = w_dy[11];
    end

    logic               r_m_valid;
    t_item              r_m_item;
    logic [1:0][PW-1:0] r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_item <= n_m_item;
            r_m_prod <= {w_py, w_px};
        end
    end

    // ---------------- X / Y division by focal length ----------------
    logic [FW-1:0]      w_focal;
    logic               w_c2_valid;
    logic [1:0][PW-1:0] w_xy_quo;
    logic [SW-1:0]      w_c2_side;
    assign w_focal = (r_focal == '0) ? FW'(1) : r_focal;

    d2d_div_chain #(.NW(PW), .DW(FW), .LANES(2), .SW(SW)) u_xydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_m_valid),
        .i_den   (w_focal),
        .i_num   (r_m_prod),
        .i_side  (SW'(r_m_item)),
        .o_valid (w_c2_valid),
        .o_quo   (w_xy_quo),
        .o_side  (w_c2_side)
    );

    // ---------------- classify, palette access ----------------
    t_item              w_c2_item;
    logic [ZW-9:0]      w_zi, w_j;
    logic               w_in_rng, w_beyond;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic signed [47:0] w_x, w_y;
    logic [23:0]        w_rdata;
    t_kind              n_f_kind;

    assign w_c2_item = t_item'(w_c2_side);
    assign w_zi      = w_c2_item.z[ZW-1:8];
    assign w_in_rng  = (w_zi >= (ZW-8)'(r_near)) && (w_zi <= (ZW-8)'(r_far));
    assign w_beyond  = (w_zi > (ZW-8)'(r_far));
    assign w_j       = w_zi - (ZW-8)'(r_near);
    assign w_raddr   = (w_j > (ZW-8)'(PALETTE_DEPTH - 1)) ? AW'(PALETTE_DEPTH - 1)
                                                          : w_j[AW-1:0];
    assign w_we      = w_adv && w_c2_valid && w_c2_item.cmd
                       && ({1'b0, w_c2_item.pal_idx} < 13'(PALETTE_DEPTH));
    // magnitudes stay below 2^46, so the 48-bit range never saturates
    assign w_x = w_c2_item.sx ? -$signed(48'(w_xy_quo[0])) : $signed(48'(w_xy_quo[0]));
    assign w_y = (w_c2_item.sy ? -$signed(48'(w_xy_quo[1])) : $signed(48'(w_xy_quo[1])))
                 + $signed({{24{r_mount[23]}}, r_mount});

    always_comb begin
        if (w_c2_item.skip) begin
            n_f_kind = KIND_SKIP;
        end else if (w_c2_item.unm) begin
            n_f_kind = KIND_UNM;
        end else if (w_in_rng) begin
            n_f_kind = KIND_RANGE;
        end else if (w_beyond) begin
            n_f_kind = KIND_FAR;
        end else begin
            n_f_kind = KIND_NEAR;
        end
    end

    d2d_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_c2_item.pal_idx[AW-1:0]),
        .i_wdata (w_c2_item.pal_color),
        .i_re    (w_adv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic               r_f_valid;
    t_kind              r_f_kind;
    logic signed [36:0] r_f_z;
    logic signed [47:0] r_f_x, r_f_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_adv) begin
            r_f_valid <= w_c2_valid && !w_c2_item.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_kind <= n_f_kind;
            case (n_f_kind)
                KIND_SKIP: begin
                    r_f_z <= '0;
                    r_f_x <= '0;
                    r_f_y <= '0;
                end
                KIND_UNM: begin
                    r_f_z <= -37'sd256;
                    r_f_x <= -48'sd256;
                    r_f_y <= -48'sd256;
                end
                default: begin
                    r_f_z <= $signed({1'b0, w_c2_item.z});
                    r_f_x <= w_x;
                    r_f_y <= w_y;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    t_kind              r_o_kind;
    logic signed [36:0] r_o_z;
    logic signed [47:0] r_o_x, r_o_y;
    logic [23:0]        r_o_color, n_o_color;
    logic               r_o_wr, n_o_wr;

    always_comb begin
        n_o_wr    = r_col_en;
        n_o_color = COLOR_NEAR;
        case (r_f_kind)
            KIND_SKIP: n_o_wr = 1'b0;
            KIND_UNM: begin
                n_o_wr    = 1'b1;
                n_o_color = COLOR_GRAY;
            end
            KIND_RANGE: n_o_color = r_col_en ? w_rdata : COLOR_NEAR;
            KIND_FAR:   n_o_color = r_col_en ? COLOR_FAR : COLOR_NEAR;
            default:    n_o_color = COLOR_NEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_kind  <= r_f_kind;
            r_o_z     <= r_f_z;
            r_o_x     <= r_f_x;
            r_o_y     <= r_f_y;
            r_o_color <= n_o_color;
            r_o_wr    <= n_o_wr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_kind    = r_o_kind;
    assign o_depth_z       = r_o_z;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_pixel_color   = r_o_color;
    assign o_color_written = r_o_wr;

    // ---------------- assertions ----------------
    a_skip_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_kind == KIND_SKIP) |->
            (!o_color_written && o_depth_z == 37'sd0 && o_pixel_color == 24'd0))
        else $error("skipped pixel carries data");

    a_unm_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_kind == KIND_UNM) |->
            (o_depth_z == -37'sd256 && o_color_written && o_pixel_color == COLOR_GRAY))
        else $error("unmatched pixel not marked");

    a_far_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_kind == KIND_FAR) |->
            (o_color_written == r_col_en))
        else $error("far pixel colour flag wrong");
endmodule
